// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL files; hc3_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define HC3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HC3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/hc3_pkg.sv -----
package hc3_pkg;

  localparam int unsigned Modulus = 26;
  localparam int unsigned ModW = 5;
  localparam int unsigned SumW = 12;
  localparam int unsigned KeyW = 45;
  localparam int unsigned QueueDepth = 2;
  localparam logic [KeyW-1:0] KeyReset = 45'd20962312099377;
  localparam logic [6:0] LowerBase = 7'd97;
  localparam logic [6:0] UpperBase = 7'd65;
  // Offsets that make (byte - base) non-negative while keeping it congruent mod 26.
  localparam logic [8:0] LowerOffset = 9'd7;
  localparam logic [8:0] UpperOffset = 9'd13;
  localparam logic [15:0] Recip = 16'd2521;

  typedef enum logic {
    CFG_KEY = 1'b0,
    CFG_DIR = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [ModW-1:0] p0;
    logic [ModW-1:0] p1;
    logic [ModW-1:0] p2;
    logic            dir;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Remainder by 26 of a value below 4096, using a scaled reciprocal.
  function automatic logic [ModW-1:0] mod26(input logic [SumW-1:0] v);
    logic [27:0] prod;
    logic [SumW-1:0] q;
    logic [SumW-1:0] r;
    prod = 28'(v) * 28'(Recip);
    q = prod[27:16];
    r = v - SumW'(q * SumW'(Modulus));
    if (r >= SumW'(Modulus)) begin
      r = r - SumW'(Modulus);
    end
    return r[ModW-1:0];
  endfunction

endpackage

// ----- sv/hc3_front.sv -----
module hc3_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   dir_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_byte_i,
  input  hc3_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output hc3_pkg::group_t        group_o
);
  import hc3_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic [ModW-1:0] held_q [2];
  logic [8:0] shifted;
  logic [ModW-1:0] idx;
  logic accept;
  logic third;

  assign shifted = {1'b0, char_byte_i} + (dir_i ? UpperOffset : LowerOffset);
  assign idx = mod26(SumW'(shifted));
  assign third = pos_q[1];
  assign in_stall_o = third && q_status_i.full;
  assign accept = in_valid_i && !in_stall_o;
  assign push_o = accept && third;

  assign group_o.p0 = held_q[0];
  assign group_o.p1 = held_q[1];
  assign group_o.p2 = idx;
  assign group_o.dir = dir_i;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = third ? 2'd0 : pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      held_q[0] <= '0;
      held_q[1] <= '0;
    end else begin
      pos_q <= pos_d;
      if (accept && !third) begin
        held_q[pos_q[0]] <= idx;
      end
    end
  end

endmodule

// ----- sv/hc3_queue.sv -----
module hc3_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hc3_pkg::group_t        group_i,
  input  logic                   pop_i,
  output hc3_pkg::group_t        group_o,
  output hc3_pkg::queue_status_t status_o
);
  import hc3_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  group_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign status_o.full = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop = pop_i && !status_o.empty;
  assign group_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= group_i;
    end
  end

endmodule

// ----- sv/hc3_back.sv -----
`include "assert_macros.svh"

module hc3_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [hc3_pkg::KeyW-1:0]   key_i,
  input  hc3_pkg::group_t            group_i,
  input  hc3_pkg::queue_status_t     q_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [6:0]                 out_byte_o,
  output logic                       group_last_o
);
  import hc3_pkg::*;

  logic a_valid_q, a_valid_d;
  logic [1:0] row_q, row_d;
  logic [SumW-1:0] sum_q [3];
  logic [SumW-1:0] sum_d [3];
  logic dir_q;
  logic out_valid_q, out_valid_d;
  logic [6:0] out_byte_q;
  logic last_q;
  logic out_load, emit, a_done;
  logic [SumW-1:0] sel_sum;
  logic [ModW-1:0] residue;

  assign out_load = !out_valid_q || !out_stall_i;
  assign emit = out_load && a_valid_q;
  assign a_done = emit && (row_q == 2'd2);
  assign pop_o = !q_status_i.empty && (!a_valid_q || a_done);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(key_i[ModW*(3*r) +: ModW]) * SumW'(group_i.p0)
               + SumW'(key_i[ModW*(3*r+1) +: ModW]) * SumW'(group_i.p1)
               + SumW'(key_i[ModW*(3*r+2) +: ModW]) * SumW'(group_i.p2);
    end
  end

  always_comb begin
    unique case (row_q)
      2'd0: sel_sum = sum_q[0];
      2'd1: sel_sum = sum_q[1];
      default: sel_sum = sum_q[2];
    endcase
  end

  assign residue = mod26(sel_sum);

  always_comb begin
    a_valid_d = a_valid_q;
    row_d = row_q;
    if (pop_o) begin
      a_valid_d = 1'b1;
      row_d = 2'd0;
    end else if (a_done) begin
      a_valid_d = 1'b0;
      row_d = 2'd0;
    end else if (emit) begin
      row_d = row_q + 2'd1;
    end
    out_valid_d = out_load ? a_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      row_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      row_q <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sum_q <= sum_d;
      dir_q <= group_i.dir;
    end
    if (emit) begin
      out_byte_q <= (dir_q ? LowerBase : UpperBase) + 7'(residue);
      last_q <= (row_q == 2'd2);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign group_last_o = last_q;

  `HC3_ASSERT(row_in_range_a, row_q != 2'd3, "row counter out of range")
  `HC3_ASSERT(idle_row_zero_a, !a_valid_q |-> row_q == 2'd0, "row counter moved while idle")
  `HC3_ASSERT(no_pop_mid_group_a, (a_valid_q && !a_done) |-> !pop_o,
              "group taken while another is still being emitted")

endmodule

// ----- sv/hill_cipher_3x3_mod26_top.sv -----
// Hill cipher, 3x3 key mod 26: one letter accepted per cycle, one letter delivered per cycle
// while out_stall_i is low. Three results follow each third letter; its group passes through
// the two-group queue, the sum registers and the output register before the first one shows.
// Input stalls only on a third letter while the group queue is full.
// Asynchronous active-low reset empties the queue and pipeline, clears the held letters
// and loads the default key and encrypt direction.
module hill_cipher_3x3_mod26_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [6:0]               out_byte_o,
  output logic                     group_last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  hc3_pkg::cfg_index_e      cfg_index_i,
  input  logic [hc3_pkg::KeyW-1:0] cfg_data_i
);
  import hc3_pkg::*;

  logic [KeyW-1:0] key_q;
  logic dir_q;
  logic push, pop;
  group_t front_group, queue_group;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
      dir_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY: key_q <= cfg_data_i;
        CFG_DIR: dir_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  hc3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_i       (dir_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .group_o     (front_group)
  );

  hc3_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .group_i  (front_group),
    .pop_i    (pop),
    .group_o  (queue_group),
    .status_o (q_status)
  );

  hc3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_q),
    .group_i      (queue_group),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .group_last_o (group_last_o)
  );

endmodule
